>>> rtl/core/record_store_with_free_list_top_defines.svh
// Assertion macros for the record store.
`ifndef RECORD_STORE_WITH_FREE_LIST_TOP_DEFINES_SVH
`define RECORD_STORE_WITH_FREE_LIST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RSFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsfl assertion failed");
`define RSFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsfl assertion failed");
`else
`define RSFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/rsfl_pkg.sv
// Shared types and constants of the record store.
package rsfl_pkg;

    localparam int DEPTH       = 1024;
    localparam int DATA_W      = 32;
    localparam int POS_W       = $clog2(DEPTH);
    localparam int LINK_W      = POS_W + 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((POS_W + DATA_W + LINK_W + 7) / 8) * 8;

    localparam logic signed [LINK_W-1:0] LINK_END = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } dp_ctl_t;

endpackage

>>> rtl/core/rsfl_ctrl.sv
// Request sequencer and result handshake of the record store.
module rsfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rsfl_pkg::dp_ctl_t ctl
);
    import rsfl_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready   = (state_reg == IDLE);
    assign out_valid  = out_valid_reg;
    assign ctl.accept = in_valid && (state_reg == IDLE);
    assign ctl.commit = (state_reg == EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            IDLE:
            begin
                if (ctl.accept)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next     = IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/rsfl_dp.sv
// Record memories, free list head, slot count and result register.
module rsfl_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  rsfl_pkg::dp_ctl_t                        ctl,
    input  rsfl_pkg::cmd_t                           in_command,
    input  logic [rsfl_pkg::POS_W-1:0]               in_position,
    input  logic [rsfl_pkg::DATA_W-1:0]              in_payload,
    output rsfl_pkg::status_t                        status,
    output logic [rsfl_pkg::POS_W-1:0]               slot,
    output logic [rsfl_pkg::DATA_W-1:0]              read_payload,
    output logic signed [rsfl_pkg::LINK_W-1:0]       read_link
);
    import rsfl_pkg::*;

    logic [DATA_W-1:0]        payload_mem [DEPTH];
    logic signed [LINK_W-1:0] link_mem    [DEPTH];

    cmd_t                     cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [DATA_W-1:0]        data_reg;
    logic [DATA_W-1:0]        rd_payload_reg;
    logic signed [LINK_W-1:0] rd_link_reg;
    logic [POS_W-1:0]         rd_addr;

    logic signed [LINK_W-1:0] free_head_reg;
    logic signed [LINK_W-1:0] free_head_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    status_t                  status_reg;
    status_t                  status_next;
    logic [POS_W-1:0]         slot_reg;
    logic [POS_W-1:0]         slot_next;
    logic [DATA_W-1:0]        rpay_reg;
    logic [DATA_W-1:0]        rpay_next;
    logic signed [LINK_W-1:0] rlink_reg;
    logic signed [LINK_W-1:0] rlink_next;

    logic                     pay_we;
    logic                     link_we;
    logic [POS_W-1:0]         wr_addr;
    logic signed [LINK_W-1:0] link_wdata;

    assign rd_addr = (in_command == CMD_ADD) ? free_head_reg[POS_W-1:0] : in_position;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg        <= in_command;
            pos_reg        <= in_position;
            data_reg       <= in_payload;
            rd_payload_reg <= payload_mem[rd_addr];
            rd_link_reg    <= link_mem[rd_addr];
        end
    end

    always_comb
    begin
        free_head_next = free_head_reg;
        count_next     = count_reg;
        status_next    = ST_OK;
        slot_next      = pos_reg;
        rpay_next      = '0;
        rlink_next     = '0;
        pay_we         = 1'b0;
        link_we        = 1'b0;
        wr_addr        = pos_reg;
        link_wdata     = LINK_END;
        if (cmd_reg == CMD_ADD)
        begin
            if (!free_head_reg[LINK_W-1])
            begin
                slot_next      = free_head_reg[POS_W-1:0];
                wr_addr        = free_head_reg[POS_W-1:0];
                free_head_next = rd_link_reg;
                pay_we         = 1'b1;
                link_we        = 1'b1;
            end
            else if (count_reg != CNT_W'(DEPTH))
            begin
                slot_next  = count_reg[POS_W-1:0];
                wr_addr    = count_reg[POS_W-1:0];
                count_next = count_reg + CNT_W'(1);
                pay_we     = 1'b1;
                link_we    = 1'b1;
            end
            else
            begin
                status_next = ST_FULL;
                slot_next   = '0;
            end
        end
        else if (count_reg == '0)
        begin
            status_next = ST_EMPTY;
        end
        else if (CNT_W'(pos_reg) >= count_reg)
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_READ:
                begin
                    rpay_next  = rd_payload_reg;
                    rlink_next = rd_link_reg;
                end
                CMD_WRITE:
                begin
                    pay_we = 1'b1;
                end
                CMD_DELETE:
                begin
                    link_we        = 1'b1;
                    link_wdata     = free_head_reg;
                    free_head_next = LINK_W'(pos_reg);
                end
                default:
                begin
                    pay_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && pay_we)
        begin
            payload_mem[wr_addr] <= data_reg;
        end
        if (ctl.commit && link_we)
        begin
            link_mem[wr_addr] <= link_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= LINK_END;
            count_reg     <= '0;
        end
        else if (ctl.commit)
        begin
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            rpay_reg   <= rpay_next;
            rlink_reg  <= rlink_next;
        end
    end

    assign status       = status_reg;
    assign slot         = slot_reg;
    assign read_payload = rpay_reg;
    assign read_link    = rlink_reg;

endmodule

>>> rtl/core/record_store_with_free_list_top.sv
// Top level of the record store with a last-in-first-out free list.
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: command; tdata: position, payload
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: slot, payload, link
//
//  Each request has an accept cycle, which reads the slot (or the free list
//  head) from the synchronous record memories, and a commit cycle, which
//  updates memory and loads the result register. A new request is taken
//  only after the last one has committed; a result held by m_axis_tready
//  stalls the commit. Reset leaves the free list empty
//  and the slot count at zero; record memories are not cleared.
module record_store_with_free_list_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rsfl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // position, payload, zero pad
    input  logic [rsfl_pkg::CMD_W-1:0]           s_axis_tuser,  // command
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rsfl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // slot, read_payload, read_link, pad
    output logic [rsfl_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);
    import rsfl_pkg::*;

`include "record_store_with_free_list_top_defines.svh"

    dp_ctl_t                  ctl;
    status_t                  status;
    logic [POS_W-1:0]         slot;
    logic [DATA_W-1:0]        read_payload;
    logic signed [LINK_W-1:0] read_link;

    rsfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    rsfl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_command   (cmd_t'(s_axis_tuser)),
        .in_position  (s_axis_tdata[POS_W-1:0]),
        .in_payload   (s_axis_tdata[POS_W+DATA_W-1:POS_W]),
        .status       (status),
        .slot         (slot),
        .read_payload (read_payload),
        .read_link    (read_link)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {(OUT_TDATA_W - POS_W - DATA_W - LINK_W)'(0),
                           read_link, read_payload, slot};

    `RSFL_ASSERT_NEXT(a_one_request_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RSFL_ASSERT_IMP(a_commit_needs_room, clk, rst_n, ctl.commit, !m_axis_tvalid || m_axis_tready)
    `RSFL_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, ctl.commit, m_axis_tvalid)
    `RSFL_ASSERT_IMP(a_no_accept_and_commit, clk, rst_n, ctl.accept, !ctl.commit)

endmodule

>>> tb/tb.sv
// Testbench for the record store with a LIFO free list: stream stimulus, predictor and checks.
`timescale 1ns / 100ps

module tb;
    import rsfl_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic [POS_W-1:0]         slot;
        logic [DATA_W-1:0]        payload;
        logic signed [LINK_W-1:0] link;
    } record_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    logic [DATA_W-1:0]        rec_payload [DEPTH];
    logic signed [LINK_W-1:0] rec_link [DEPTH];
    logic signed [LINK_W-1:0] free_head;
    int                       slots_used;

    record_result_t pending_results [$];
    int src_idle_pct;
    int snk_idle_pct;
    int rx_hold_left;
    int errors;
    int requests_sent;
    int results_checked;
    int status_seen [4];

    record_store_with_free_list_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic record_result_t apply_request(input cmd_t cmd,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] data);
        record_result_t r;
        r.status  = ST_OK;
        r.slot    = pos;
        r.payload = '0;
        r.link    = '0;
        if (cmd == CMD_ADD)
        begin
            if (free_head != LINK_END)
            begin
                r.slot              = free_head[POS_W-1:0];
                free_head           = rec_link[r.slot];
                rec_payload[r.slot] = data;
                rec_link[r.slot]    = LINK_END;
            end
            else if (slots_used < DEPTH)
            begin
                r.slot              = slots_used[POS_W-1:0];
                rec_payload[r.slot] = data;
                rec_link[r.slot]    = LINK_END;
                slots_used++;
            end
            else
            begin
                r.status = ST_FULL;
                r.slot   = '0;
            end
        end
        else if (slots_used == 0)
            r.status = ST_EMPTY;
        else if (int'(pos) >= slots_used)
            r.status = ST_RANGE;
        else
        begin
            case (cmd)
                CMD_READ:
                begin
                    r.payload = rec_payload[pos];
                    r.link    = rec_link[pos];
                end
                CMD_WRITE:
                    rec_payload[pos] = data;
                default:
                begin
                    rec_link[pos] = free_head;
                    free_head     = {1'b0, pos};
                end
            endcase
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic send_request(input cmd_t cmd, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - POS_W - DATA_W){1'b0}}, data, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), apply_request(cmd, pos, data));
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        record_result_t want;
        record_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status  = status_t'(m_axis_tuser);
            got.slot    = m_axis_tdata[POS_W-1:0];
            got.payload = m_axis_tdata[POS_W +: DATA_W];
            got.link    = m_axis_tdata[POS_W + DATA_W +: LINK_W];
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result status %0d slot %0d",
                                     got.status, got.slot));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.payload !== want.payload || got.link !== want.link)
                    flag_error($sformatf({"mismatch: expected status %0d slot %0d ",
                        "payload %h link %0d, got status %0d slot %0d payload %h link %0d"},
                        want.status, want.slot, want.payload, want.link,
                        got.status, got.slot, got.payload, got.link));
            end
        end
    end

    task automatic test_empty_store();
        send_request(CMD_READ, '0, '0);
        send_request(CMD_WRITE, '1, '1);
        send_request(CMD_DELETE, '0, 32'h5A5A_5A5A);
        send_request(CMD_READ, '1, '1);
    endtask

    task automatic test_basic_ops();
        send_request(CMD_ADD, '1, '0);
        send_request(CMD_ADD, '0, '1);
        send_request(CMD_ADD, 10'd7, 32'hA5A5_5A5A);
        send_request(CMD_READ, 10'd0, '0);
        send_request(CMD_READ, 10'd1, '1);
        send_request(CMD_READ, 10'd3, '0);
        send_request(CMD_WRITE, 10'd1, 32'h1234_5678);
        send_request(CMD_READ, 10'd1, '0);
        send_request(CMD_DELETE, 10'd0, '0);
        send_request(CMD_DELETE, 10'd2, '0);
        send_request(CMD_READ, 10'd2, '0);
        send_request(CMD_READ, 10'd0, '0);
        // delete twice: the free list loops back on itself
        send_request(CMD_DELETE, 10'd2, '0);
        send_request(CMD_ADD, '0, 32'hDEAD_BEEF);
        send_request(CMD_ADD, '0, 32'hCAFE_F00D);
        send_request(CMD_ADD, '0, 32'h0F0F_0F0F);
        send_request(CMD_READ, 10'd2, '0);
    endtask

    task automatic test_random(input int count, input int src_pct, input int snk_pct);
        int r;
        cmd_t cmd;
        logic [POS_W-1:0] pos;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                cmd = CMD_ADD;
            else if (r < 60)
                cmd = CMD_READ;
            else if (r < 78)
                cmd = CMD_WRITE;
            else
                cmd = CMD_DELETE;
            r = $urandom_range(0, 99);
            if (r < 5 && free_head != LINK_END)
                pos = free_head[POS_W-1:0];
            else if (r < 78 && slots_used > 0)
                pos = POS_W'($urandom_range(0, slots_used - 1));
            else if (r < 88 && slots_used < DEPTH)
                pos = POS_W'($urandom_range(slots_used, DEPTH - 1));
            else
                pos = POS_W'($urandom);
            send_request(cmd, pos, $urandom);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold_left <= 300;
        repeat (40)
            send_request(cmd_t'($urandom_range(0, 3)),
                         POS_W'($urandom_range(0, slots_used)), $urandom);
        wait_drained();
    endtask

    task automatic test_store_full();
        while (!(slots_used == DEPTH && free_head == LINK_END))
            send_request(CMD_ADD, POS_W'($urandom), $urandom);
        send_request(CMD_ADD, '1, '1);
        send_request(CMD_ADD, '0, '0);
        send_request(CMD_READ, '1, '0);
        send_request(CMD_WRITE, '1, '1);
        send_request(CMD_READ, '1, '0);
        send_request(CMD_DELETE, '1, '0);
        send_request(CMD_DELETE, '0, '0);
        send_request(CMD_READ, '0, '0);
        send_request(CMD_ADD, '0, 32'h8000_0001);
        send_request(CMD_ADD, '0, 32'h7FFF_FFFE);
        send_request(CMD_ADD, '0, 32'h1111_2222);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        free_head     = LINK_END;
        slots_used    = 0;
        rx_hold_left  = 0;
        errors        = 0;
        src_idle_pct  = 19;
        snk_idle_pct  = 45;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_basic_ops();
        test_random(100, 19, 45);
        test_random(100, 45, 19);
        test_backpressure();
        test_random(50, 0, 0);
        test_store_full();
        test_random(30, 0, 0);

        wait_drained();
        repeat (10) @(negedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        $display("Sent %0d requests, checked %0d results; %0d slots appended.",
                 requests_sent, results_checked, slots_used);
        $display("Status counts: ok %0d, empty %0d, out of range %0d, full %0d; errors %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_FULL], errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
